// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/md5f_pkg.sv =====
package md5f_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos = 6'd56;

  // Byte source for a buffer write.
  typedef enum logic [1:0] {
    SRC_MSG  = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_e;

  typedef struct packed {
    logic      wr_en;
    byte_src_e src;
    logic      cnt_inc;
    logic      len_latch;
    logic      rnd_start;
    logic      fold_en;
    logic      init;
  } md5f_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       rnd_done;
  } md5f_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_rot(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

// ===== hdl/md5f_ram.sv =====
module md5f_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hdl/md5f_datapath.sv =====
module md5f_datapath import md5f_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  md5f_cmd_t   cmd_i,
  input  logic [7:0]  message_byte_i,
  output md5f_sts_t   sts_o,
  output logic [31:0] fold_o
);
  logic [63:0] cnt_q, len_q;
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [6:0]  rnd_q;
  logic        busy_q;
  logic [7:0]  wbyte;
  logic [5:0]  pos_q;
  logic [31:0] word, f, sum, rot;
  logic [5:0]  ri;
  logic [3:0]  raddr;
  logic [5:0]  ri_next;
  logic [3:0]  lane_mask;

  // Bytes are merged into 32-bit words: four byte lanes, one RAM per lane.
  always_comb begin
    case (cmd_i.src)
      SRC_MSG:  wbyte = message_byte_i;
      SRC_PAD:  wbyte = PadByte;
      SRC_ZERO: wbyte = 8'h00;
      default:  wbyte = len_q[{pos_q[2:0], 3'b000} +: 8];
    endcase
  end

  assign ri = rnd_q[5:0];
  assign ri_next = busy_q ? 6'(rnd_q + 7'd1) : 6'd0;
  assign raddr = round_g(cmd_i.rnd_start ? 6'd0 : ri_next);
  assign lane_mask = 4'b0001 << pos_q[1:0];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    md5f_ram #(.Width(8), .Depth(16)) u_ram (
      .clk_i  (clk_i),
      .we_i   (cmd_i.wr_en && lane_mask[l]),
      .waddr_i(pos_q[5:2]),
      .wdata_i(wbyte),
      .raddr_i(raddr),
      .rdata_o(word[8*l +: 8])
    );
  end

  always_comb begin
    case (ri[5:4])
      2'd0: f = d_q ^ (b_q & (c_q ^ d_q));
      2'd1: f = c_q ^ (d_q & (b_q ^ c_q));
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    sum = a_q + f + round_k(ri) + word;
    rot = (sum << round_rot(ri)) | (sum >> (6'd32 - {1'b0, round_rot(ri)}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pos_q  <= '0;
      busy_q <= 1'b0;
      rnd_q  <= '0;
      h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
    end else begin
      if (cmd_i.wr_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 64'd8;
      end
      if (cmd_i.rnd_start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
        a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
      end else if (busy_q) begin
        if (rnd_q == 7'd64) begin
          busy_q <= 1'b0;
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
        end else begin
          rnd_q <= rnd_q + 7'd1;
          a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
        end
      end
      if (cmd_i.init) begin
        cnt_q  <= '0;
        pos_q  <= '0;
        h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_latch) begin
      len_q <= cnt_q;
    end
  end

  assign fold_o = h_q[0] ^ h_q[1] ^ h_q[2] ^ h_q[3];
  assign sts_o.pos = pos_q;
  assign sts_o.rnd_done = !busy_q && !cmd_i.rnd_start;
endmodule

// ===== hdl/md5f_ctrl.sv =====
module md5f_ctrl import md5f_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic       has_byte_i,
  input  logic       last_byte_i,
  output logic       valid_o,
  input  logic       stall_i,
  input  md5f_sts_t  sts_i,
  output md5f_cmd_t  cmd_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRun  = 3'd1;
  localparam logic [2:0] StPad  = 3'd2;
  localparam logic [2:0] StZero = 3'd3;
  localparam logic [2:0] StLen  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       fin_q, fin_d;   // padding owed after the running transform
  logic       out_q, out_d;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    out_d   = out_q;
    cmd_o   = '0;
    cmd_o.src = SRC_MSG;
    stall_o = 1'b1;
    if (out_q && !stall_i) begin
      out_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        stall_o = 1'b0;
        if (valid_i) begin
          if (has_byte_i) begin
            cmd_o.wr_en = 1'b1;
            cmd_o.cnt_inc = 1'b1;
          end
          fin_d = last_byte_i;
          if (has_byte_i && sts_i.pos == 6'd63) begin
            cmd_o.rnd_start = 1'b1;
            state_d = StRun;
          end else if (last_byte_i) begin
            state_d = StPad;
          end
        end
      end
      StRun: begin
        if (sts_i.rnd_done) begin
          state_d = fin_q ? StPad : StIdle;
        end
      end
      StPad: begin
        cmd_o.len_latch = 1'b1;
        cmd_o.wr_en = 1'b1;
        cmd_o.src = SRC_PAD;
        fin_d = 1'b0;
        if (sts_i.pos == 6'd63) begin
          cmd_o.rnd_start = 1'b1;
          state_d = StRun;
          fin_d = 1'b1;
        end else begin
          state_d = StZero;
        end
      end
      StZero: begin
        if (sts_i.pos == LenPos) begin
          state_d = StLen;
        end else begin
          cmd_o.wr_en = 1'b1;
          cmd_o.src = SRC_ZERO;
          if (sts_i.pos == 6'd63) begin
            cmd_o.rnd_start = 1'b1;
            state_d = StRun;
            fin_d = 1'b1;
          end
        end
      end
      StLen: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.src = SRC_LEN;
        if (sts_i.pos == 6'd63) begin
          cmd_o.rnd_start = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        // The fold and the restart of the chain happen at the same edge.
        if (sts_i.rnd_done && !out_q) begin
          out_d = 1'b1;
          cmd_o.fold_en = 1'b1;
          cmd_o.init = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    // A run entered from padding resumes padding with zeros, not with 0x80.
    if (state_q == StRun && sts_i.rnd_done && fin_q && state_d == StPad) begin
      state_d = StZero;
    end
  end

  // A run entered straight from an input item with last set pads from scratch.
  logic pend_q, pend_d;
  always_comb begin
    pend_d = pend_q;
    if (state_q == StIdle && valid_i) pend_d = last_byte_i;
    if (state_q == StPad) pend_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q   <= 1'b0;
      out_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      fin_q  <= fin_d;
      out_q  <= out_d;
      if (state_q == StRun && sts_i.rnd_done && pend_q) begin
        state_q <= StPad;
      end else begin
        state_q <= state_d;
      end
    end
  end

  assign valid_o = out_q;
endmodule

// ===== hdl/md5_hash_folded_core.sv =====
// Folded MD5: one input byte is taken per cycle while no block transform runs
// and no padding is written. A full 64-byte block stalls the input while its
// round loop runs. A last item adds padding and one or two transforms; the
// result waits in an output register while new input is taken.
// rst_ni is asynchronous and active low; it loads the MD5 initial words and
// clears the bit count and all handshake state.
module md5_hash_folded_core import md5f_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  message_byte_i,
  input  logic        has_byte_i,
  input  logic        last_byte_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] folded_hash_o
);
  md5f_cmd_t   cmd;
  md5f_sts_t   sts;
  logic [31:0] fold;
  logic [31:0] hash_q;

  md5f_ctrl u_ctrl (
    .clk_i, .rst_ni, .valid_i, .stall_o, .has_byte_i, .last_byte_i,
    .valid_o, .stall_i, .sts_i(sts), .cmd_o(cmd)
  );

  md5f_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .message_byte_i, .sts_o(sts), .fold_o(fold)
  );

  always_ff @(posedge clk_i) begin
    if (cmd.fold_en) begin
      hash_q <= fold;
    end
  end

  assign folded_hash_o = hash_q;
endmodule

// ===== hdl/md5f_checker.sv =====
`include "assert_macros.svh"
module md5f_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] folded_hash_o
);
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(folded_hash_o), "result dropped while stalled")
  `CHK_NEXT(a_in_hold, clk_i, rst_ni, valid_i && stall_o, valid_i, "input dropped while stalled")
  `CHK_NEXT(a_out_one, clk_i, rst_ni, valid_o && !stall_i, !valid_o, "result repeated")
  `CHK_IMPL(a_out_known, clk_i, rst_ni, valid_o, !$isunknown(folded_hash_o), "unknown result")
endmodule

bind md5_hash_folded_core md5f_checker u_chk (.*);

// ===== bench/md5_hash_folded_core_tb.sv =====
`timescale 1ns / 100ps

module md5_hash_folded_core_tb;
  import md5f_pkg::*;

  class md5_fold_board;
    logic [31:0] chain[4];
    logic [7:0] blk[64];
    logic [63:0] nbits;
    logic [31:0] pending_hashes[$];
    int errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = InitA;
      chain[1] = InitB;
      chain[2] = InitC;
      chain[3] = InitD;
      nbits = '0;
    endfunction

    function void transform();
      logic [31:0] msg[16];
      logic [31:0] a, b, c, d, f, t, s;
      int g, grp, r;
      int shifts[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      for (int i = 0; i < 16; i++)
        msg[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int i = 0; i < 64; i++) begin
        grp = i / 16;
        case (grp)
          0: begin f = d ^ (b & (c ^ d)); g = i; end
          1: begin f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16; end
          2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
          default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
        endcase
        // Sine-derived round constant: floor(abs(sin(i+1)) * 2^32).
        s = a + f + sine_word(i) + msg[g];
        r = shifts[grp * 4 + i % 4];
        t = d; d = c; c = b;
        b = b + ((s << r) | (s >> (32 - r)));
        a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function logic [31:0] sine_word(int i);
      real v;
      v = $sin(i + 1.0);
      if (v < 0) v = -v;
      return 32'(longint'($floor(v * 4294967296.0)));
    endfunction

    function int put(int pos, logic [7:0] v);
      blk[pos] = v;
      if (pos == 63) begin
        transform();
        return 0;
      end
      return pos + 1;
    endfunction

    function void note_transfer(logic [7:0] byt, logic has, logic last);
      int pos;
      logic [63:0] len;
      pos = int'(nbits[8:3]);
      if (has) begin
        pos = put(pos, byt);
        nbits += 64'd8;
      end
      if (!last) return;
      len = nbits;
      pos = put(pos, PadByte);
      while (pos != int'(LenPos)) pos = put(pos, 8'h00);
      for (int k = 0; k < 8; k++) pos = put(pos, len[8*k +: 8]);
      pending_hashes.push_back(chain[0] ^ chain[1] ^ chain[2] ^ chain[3]);
      restart();
    endfunction

    function void check_hash(logic [31:0] got);
      logic [31:0] want;
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash transfer, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_hashes.pop_front();
      if (got !== want) begin
        $display("%0t: folded_hash mismatch, expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [7:0] message_byte_i = '0;
  logic has_byte_i = 1'b0;
  logic last_byte_i = 1'b0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [31:0] folded_hash_o;

  md5_fold_board board = new();
  int cycle_count = 0;
  bit calm = 1'b0;

  always #4 clk_i = ~clk_i;

  md5_hash_folded_core dut (.*);

  // Receiver side: random stall and result checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) board.check_hash(folded_hash_o);
      stall_i <= !calm && ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 2000000) begin
      $display("** md5_hash_folded_core: FAILED **");
      $finish;
    end
  end

  // Valid stays high after a transfer so that items can follow back to back.
  task automatic send_item(logic [7:0] byt, logic has, logic last);
    while (!calm && $urandom_range(99) < 18) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    message_byte_i <= byt;
    has_byte_i <= has;
    last_byte_i <= last;
    do @(posedge clk_i); while (stall_o);
    board.note_transfer(byt, has, last);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1));
    end
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (board.pending_hashes.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, idle item, field extremes, padding boundaries.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    drain();
    // Message lengths around the point where the length spills into a second block.
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
    drain();

    // Pause on an empty pipeline, then a stretch with no idling.
    calm = 1'b1;
    send_message(130);
    drain();
    calm = 1'b0;

    // Items already sent by the directed part above.
    sent = 376;
    while (sent < 1850) begin
      int len;
      case ($urandom_range(9))
        0: len = 0;
        1: len = $urandom_range(120, 56);
        default: len = $urandom_range(12, 1);
      endcase
      send_message(len);
      sent += len + 1;
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending_hashes.size() == 0)
      $display("** md5_hash_folded_core: PASSED **");
    else
      $display("** md5_hash_folded_core: FAILED **");
    $finish;
  end
endmodule
